/* hw/rtl/bcs_pkg.sv */
`timescale 1ns / 1ps

package bcs_pkg;

    localparam int VOICES = 16;
    localparam int VIDX_W = $clog2(VOICES);

    localparam logic [3:0] CFG_FOLD = 4'd0;
    localparam logic [3:0] CFG_KIND = 4'd1;
    localparam logic [3:0] CFG_MASH = 4'd2;
    localparam logic [3:0] CFG_WET  = 4'd3;

    localparam logic signed [40:0] F_Q22  = 41'sd1737338;
    localparam logic signed [40:0] K_Q22  = 41'sd5931642;
    localparam logic signed [40:0] T_Q22  = 41'sd2644936;
    localparam logic signed [40:0] U_Q22  = 41'sd3784810;
    localparam logic signed [40:0] TF_Q22 = 41'sd1095568;
    localparam logic signed [40:0] DIV_R  = 41'sd2748779069;

    localparam logic signed [40:0] THREE24  = 41'sd50331648;
    localparam logic signed [40:0] FIVE24   = 41'sd83886080;
    localparam logic signed [40:0] TWENTY24 = 41'sd335544320;
    localparam logic signed [40:0] KHALF    = 41'sd32768;
    localparam logic signed [40:0] WONE     = 41'sd65536;

    localparam logic [5:0] SH_DIV = 6'd38;
    localparam logic [5:0] SH_Q22 = 6'd22;
    localparam logic [5:0] SH_Q24 = 6'd24;
    localparam logic [5:0] SH_MIX = 6'd17;
    localparam logic [5:0] SH_WET = 6'd16;
    localparam logic [5:0] SH_NONE = 6'd0;

    localparam logic signed [83:0] MAX40 = 84'sd549755813887;
    localparam logic signed [83:0] MIN40 = -84'sd549755813888;
    localparam logic signed [83:0] MAX32 = 84'sd2147483647;
    localparam logic signed [83:0] MIN32 = -84'sd2147483648;

    typedef struct packed {
        logic [3:0]         channel;
        logic signed [31:0] audio_in;
        logic signed [31:0] fold_mod;
    } in_word_t;

    typedef struct packed {
        logic [3:0]         channel_out;
        logic signed [31:0] audio_out;
    } out_word_t;

    typedef struct packed {
        logic signed [40:0] a;
        logic signed [40:0] b;
        logic signed [83:0] c;
        logic [5:0]         sh;
        logic               rnd;
    } mau_req_t;

    function automatic logic signed [39:0] sat40(input logic signed [83:0] v);
        if (v > MAX40)
            return MAX40[39:0];
        else if (v < MIN40)
            return MIN40[39:0];
        else
            return v[39:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [83:0] v);
        if (v > MAX32)
            return MAX32[31:0];
        else if (v < MIN32)
            return MIN32[31:0];
        else
            return v[31:0];
    endfunction

endpackage

/* hw/rtl/bitmash_svf_chebyshev_shaper.sv */
`timescale 1ns / 1ps
// Channel  | Signals                                   | Word
// sample   | sample_valid, sample_ready, sample        | channel, audio_in, fold_mod
// result   | result_valid, result_ready, result        | channel_out, audio_out
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | register index and value
//
// Each sample word sends 63 products through the one multiply-add unit, plus the
// split, fix and output steps that do not use it.
// The unit splits each product into two 41 by 21 bit partial products.
// Reset sets the config registers to their defaults and clears the sequencer and the filter state of all voices.
// A waiting result word is held in an output register, so a new sample word
// can be taken before the previous result is read.

module bitmash_svf_chebyshev_shaper (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  bcs_pkg::in_word_t    sample,
    output logic                 result_valid,
    input  logic                 result_ready,
    output bcs_pkg::out_word_t   result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [3:0]           cfg_index,
    input  logic [16:0]          cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    localparam logic [4:0] P_SPLIT = 5'd0;
    localparam logic [4:0] P_DIV   = 5'd1;
    localparam logic [4:0] P_FIX   = 5'd2;
    localparam logic [4:0] P_L1    = 5'd3;
    localparam logic [4:0] P_L2    = 5'd4;
    localparam logic [4:0] P_L3    = 5'd5;
    localparam logic [4:0] P_L4    = 5'd6;
    localparam logic [4:0] P_L5    = 5'd7;
    localparam logic [4:0] P_L6    = 5'd8;
    localparam logic [4:0] P_L7    = 5'd9;
    localparam logic [4:0] P_L8    = 5'd10;
    localparam logic [4:0] P_S1    = 5'd11;
    localparam logic [4:0] P_S2    = 5'd12;
    localparam logic [4:0] P_S3    = 5'd13;
    localparam logic [4:0] P_S4    = 5'd14;
    localparam logic [4:0] P_S5    = 5'd15;
    localparam logic [4:0] P_S6    = 5'd16;
    localparam logic [4:0] P_S7    = 5'd17;
    localparam logic [4:0] P_O     = 5'd18;
    localparam logic [4:0] P_M1    = 5'd19;
    localparam logic [4:0] P_M2    = 5'd20;

    localparam logic signed [39:0] LIM35 = 40'sd34359738368;
    localparam logic signed [83:0] LIM26 = 84'sd67108864;

    logic [1:0]                 state_reg;
    logic [4:0]                 pc_reg;
    logic [1:0]                 pass_reg;
    logic [16:0]                fold_reg;
    logic signed [16:0]         kind_reg;
    logic signed [5:0]          mash_reg;
    logic [16:0]                wet_reg;
    logic                       out_valid_reg;
    logic signed [39:0]         lp_reg [bcs_pkg::VOICES];
    logic signed [39:0]         bp_reg [bcs_pkg::VOICES];

    logic [3:0]                 ch_reg;
    logic signed [31:0]         aud_reg;
    logic signed [31:0]         fm_reg;
    logic signed [32:0]         q_reg;
    logic signed [32:0]         e_reg;
    logic [33:0]                m_reg;
    logic                       nneg_reg;
    logic signed [26:0]         s_reg;
    logic signed [39:0]         bl_reg;
    logic signed [39:0]         bb_reg;
    logic signed [39:0]         xin_reg;
    logic signed [39:0]         t_reg;
    logic signed [39:0]         low_reg;
    logic signed [39:0]         band_reg;
    logic signed [39:0]         high_reg;
    logic signed [27:0]         sx_reg;
    logic signed [29:0]         x2_reg;
    logic signed [47:0]         c3_reg;
    logic signed [47:0]         c5_reg;
    logic signed [83:0]         prod_reg;
    logic signed [47:0]         ret_reg;
    logic signed [39:0]         o_reg;
    logic signed [31:0]         fin_reg;
    bcs_pkg::out_word_t         out_reg;

    logic                       accept;
    logic                       alu_pc;
    logic                       consume;
    logic                       load_out;
    logic                       mau_start;
    logic                       mau_done;
    logic signed [83:0]         mres;
    bcs_pkg::mau_req_t          mreq;
    logic [bcs_pkg::VIDX_W-1:0] vidx;

    logic signed [7:0]          sh_full;
    logic [5:0]                 shamt;
    logic [31:0]                mag;
    logic [32:0]                mask33;
    logic [32:0]                kept;
    logic signed [32:0]         q_next;
    logic signed [32:0]         e_next;
    logic [33:0]                fold34;
    logic signed [33:0]         n_val;
    logic [33:0]                nm;
    logic [25:0]                q0;
    logic [33:0]                rem;
    logic [25:0]                qf;
    logic signed [26:0]         s_next;
    logic signed [40:0]         diff41;
    logic signed [39:0]         yc;
    logic signed [83:0]         xr;
    logic signed [47:0]         val;
    logic signed [47:0]         ret_next;
    logic signed [55:0]         w56;
    logic signed [39:0]         xin_next;

    assign vidx         = ch_reg[bcs_pkg::VIDX_W-1:0];
    assign accept       = sample_valid && sample_ready;
    assign sample_ready = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign alu_pc       = (pc_reg == P_SPLIT) || (pc_reg == P_FIX) || (pc_reg == P_O);
    assign mau_start    = (state_reg == S_RUN) && !alu_pc;
    assign consume      = (state_reg == S_WAIT) && mau_done;
    assign load_out     = (state_reg == S_OUT) && (!out_valid_reg || result_ready);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        sh_full = 8'sd24 - 8'(mash_reg);
        if (sh_full < 8'sd0)
            shamt = 6'd0;
        else if (sh_full > 8'sd32)
            shamt = 6'd32;
        else
            shamt = sh_full[5:0];
        mag    = aud_reg[31] ? 32'(-aud_reg) : 32'(aud_reg);
        mask33 = (33'd1 << shamt) - 33'd1;
        kept   = {1'b0, mag} & ~mask33;
        q_next = aud_reg[31] ? -$signed(kept) : $signed(kept);
        e_next = 33'(aud_reg) - q_next;
        fold34 = {17'd0, fold_reg};
        n_val  = $signed((fold34 << 11) + (fold34 << 9)) + 34'(fm_reg);
        nm     = n_val[33] ? 34'(-n_val) : 34'(n_val);

        q0     = mres[25:0];
        rem    = m_reg - (({8'd0, q0} << 6) + ({8'd0, q0} << 5) + ({8'd0, q0} << 2));
        qf     = q0 + ((rem >= 34'd100) ? 26'd1 : 26'd0);
        s_next = nneg_reg ? -$signed({1'b0, qf}) : $signed({1'b0, qf});

        diff41 = 41'(xin_reg) - 41'(low_reg);
        if (low_reg > LIM35)
            yc = LIM35;
        else if (low_reg < -LIM35)
            yc = -LIM35;
        else
            yc = low_reg;
        if (mres > LIM26)
            xr = LIM26;
        else if (mres < -LIM26)
            xr = -LIM26;
        else
            xr = mres;

        val = 48'(mres);
        unique case (pass_reg)
            2'd0:    ret_next = -val;
            2'd2:    ret_next = ret_reg - ((val <<< 2) + (val <<< 1));
            default: ret_next = ret_reg + (val <<< 2);
        endcase
        xin_next = (pass_reg == 2'd1) ? -40'(e_reg) : 40'(e_reg);
        w56 = (56'(ret_reg) <<< 6) + (56'(ret_reg) <<< 4);
    end

    always_comb
    begin
        mreq.a   = '0;
        mreq.b   = '0;
        mreq.c   = '0;
        mreq.sh  = bcs_pkg::SH_Q22;
        mreq.rnd = 1'b1;
        unique case (pc_reg)
            P_DIV:
            begin
                mreq.a   = $signed({7'd0, m_reg});
                mreq.b   = bcs_pkg::DIV_R;
                mreq.sh  = bcs_pkg::SH_DIV;
                mreq.rnd = 1'b0;
            end
            P_L1:
            begin
                mreq.a = bcs_pkg::F_Q22;
                mreq.b = 41'(xin_reg);
            end
            P_L2:
            begin
                mreq.a = bcs_pkg::TF_Q22;
                mreq.b = 41'(t_reg);
            end
            P_L3:
            begin
                mreq.a = 41'(t_reg);
                mreq.b = bcs_pkg::U_Q22;
            end
            P_L4:
            begin
                mreq.a = bcs_pkg::F_Q22;
                mreq.b = 41'(bcs_pkg::sat40(84'(diff41)));
            end
            P_L5:
            begin
                mreq.a = 41'(t_reg);
                mreq.b = bcs_pkg::T_Q22;
            end
            P_L6:
            begin
                mreq.a = bcs_pkg::K_Q22;
                mreq.b = 41'(band_reg);
            end
            P_L7:
            begin
                mreq.a = bcs_pkg::F_Q22;
                mreq.b = 41'(high_reg);
            end
            P_L8:
            begin
                mreq.a = bcs_pkg::F_Q22;
                mreq.b = 41'(band_reg);
            end
            P_S1:
            begin
                mreq.a  = 41'(yc);
                mreq.b  = 41'(s_reg);
                mreq.sh = bcs_pkg::SH_Q24;
            end
            P_S2:
            begin
                mreq.a  = 41'(sx_reg);
                mreq.b  = 41'(sx_reg);
                mreq.sh = bcs_pkg::SH_Q24;
            end
            P_S3:
            begin
                mreq.a  = (41'(x2_reg) <<< 2) - bcs_pkg::THREE24;
                mreq.b  = 41'(sx_reg);
                mreq.sh = bcs_pkg::SH_Q24;
            end
            P_S4:
            begin
                mreq.a  = (41'(x2_reg) <<< 4) - bcs_pkg::TWENTY24;
                mreq.b  = 41'(x2_reg);
                mreq.sh = bcs_pkg::SH_Q24;
            end
            P_S5:
            begin
                mreq.a  = 41'(t_reg) + bcs_pkg::FIVE24;
                mreq.b  = 41'(sx_reg);
                mreq.sh = bcs_pkg::SH_Q24;
            end
            P_S6:
            begin
                mreq.a   = 41'(c5_reg);
                mreq.b   = bcs_pkg::KHALF + 41'(kind_reg);
                mreq.sh  = bcs_pkg::SH_NONE;
                mreq.rnd = 1'b0;
            end
            P_S7:
            begin
                mreq.a  = 41'(c3_reg);
                mreq.b  = bcs_pkg::KHALF - 41'(kind_reg);
                mreq.c  = prod_reg;
                mreq.sh = bcs_pkg::SH_MIX;
            end
            P_M1:
            begin
                mreq.a   = bcs_pkg::WONE - $signed({24'd0, wet_reg});
                mreq.b   = 41'(q_reg);
                mreq.sh  = bcs_pkg::SH_NONE;
                mreq.rnd = 1'b0;
            end
            P_M2:
            begin
                mreq.a  = $signed({24'd0, wet_reg});
                mreq.b  = 41'(o_reg);
                mreq.c  = prod_reg;
                mreq.sh = bcs_pkg::SH_WET;
            end
            default:
            begin
                mreq.rnd = 1'b0;
            end
        endcase
    end

    bcs_mau u_mau (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mau_start),
        .req   (mreq),
        .done  (mau_done),
        .res   (mres)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= P_SPLIT;
            pass_reg      <= 2'd0;
            fold_reg      <= 17'd32768;
            kind_reg      <= 17'sd0;
            mash_reg      <= 6'sd23;
            wet_reg       <= 17'd32768;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < bcs_pkg::VOICES; i++)
            begin
                lp_reg[i] <= '0;
                bp_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    bcs_pkg::CFG_FOLD: fold_reg <= cfg_data;
                    bcs_pkg::CFG_KIND: kind_reg <= $signed(cfg_data);
                    bcs_pkg::CFG_MASH: mash_reg <= $signed(cfg_data[5:0]);
                    bcs_pkg::CFG_WET:  wet_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        pc_reg    <= P_SPLIT;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (alu_pc)
                    begin
                        if (pc_reg == P_SPLIT)
                            pass_reg <= 2'd0;
                        pc_reg <= pc_reg + 5'd1;
                    end
                    else
                    begin
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    if (mau_done)
                    begin
                        state_reg <= S_RUN;
                        if (pc_reg == P_S7)
                        begin
                            if (pass_reg == 2'd3)
                            begin
                                lp_reg[vidx] <= bl_reg;
                                bp_reg[vidx] <= bb_reg;
                                pc_reg       <= P_O;
                            end
                            else
                            begin
                                pass_reg <= pass_reg + 2'd1;
                                pc_reg   <= P_L1;
                            end
                        end
                        else if (pc_reg == P_M2)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            pc_reg <= pc_reg + 5'd1;
                        end
                    end
                end
                S_OUT:
                begin
                    if (load_out)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg  <= sample.channel;
            aud_reg <= sample.audio_in;
            fm_reg  <= sample.fold_mod;
        end

        if (state_reg == S_RUN)
        begin
            if (pc_reg == P_SPLIT)
            begin
                q_reg    <= q_next;
                e_reg    <= e_next;
                m_reg    <= nm + 34'd50;
                nneg_reg <= n_val[33];
                bl_reg   <= lp_reg[vidx];
                bb_reg   <= bp_reg[vidx];
                ret_reg  <= '0;
                xin_reg  <= 40'(q_next);
            end
            else if (pc_reg == P_FIX)
            begin
                s_reg <= s_next;
            end
            else if (pc_reg == P_O)
            begin
                o_reg <= bcs_pkg::sat40(84'(w56));
            end
        end

        if (consume)
        begin
            unique case (pc_reg)
                P_L1:    t_reg    <= bcs_pkg::sat40(84'(bb_reg) + mres);
                P_L2:    t_reg    <= bcs_pkg::sat40(84'(bl_reg) + mres);
                P_L3:    low_reg  <= bcs_pkg::sat40(mres);
                P_L4:    t_reg    <= bcs_pkg::sat40(84'(bb_reg) + mres);
                P_L5:    band_reg <= bcs_pkg::sat40(mres);
                P_L6:    high_reg <= bcs_pkg::sat40(84'(xin_reg) - 84'(low_reg) - mres);
                P_L7:    bb_reg   <= bcs_pkg::sat40(84'(band_reg) + mres);
                P_L8:    bl_reg   <= bcs_pkg::sat40(84'(low_reg) + mres);
                P_S1:    sx_reg   <= 28'(xr);
                P_S2:    x2_reg   <= 30'(mres);
                P_S3:    c3_reg   <= 48'(mres);
                P_S4:    t_reg    <= 40'(mres);
                P_S5:    c5_reg   <= 48'(mres);
                P_S6:    prod_reg <= mres;
                P_S7:
                begin
                    ret_reg <= ret_next;
                    xin_reg <= xin_next;
                end
                P_M1:    prod_reg <= mres;
                P_M2:    fin_reg  <= bcs_pkg::sat32(mres);
                default:
                begin
                end
            endcase
        end

        if (load_out)
        begin
            out_reg.channel_out <= ch_reg;
            out_reg.audio_out   <= fin_reg;
        end
    end

endmodule

/* hw/rtl/bcs_mau.sv */
`timescale 1ns / 1ps

module bcs_mau (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  bcs_pkg::mau_req_t    req,
    output logic                 done,
    output logic signed [83:0]   res
);

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_LO   = 3'd1;
    localparam logic [2:0] M_HI   = 3'd2;
    localparam logic [2:0] M_SUM  = 3'd3;
    localparam logic [2:0] M_ABS  = 3'd4;
    localparam logic [2:0] M_RND  = 3'd5;

    logic [2:0]         st_reg, st_next;
    logic               done_reg, done_next;
    logic               neg_reg, neg_next;
    logic [40:0]        ma_reg, ma_next;
    logic [40:0]        mb_reg, mb_next;
    logic signed [83:0] c_reg, c_next;
    logic [5:0]         sh_reg, sh_next;
    logic               rnd_reg, rnd_next;
    logic [80:0]        acc_reg, acc_next;
    logic signed [83:0] sp_reg, sp_next;
    logic               sgn_reg, sgn_next;
    logic [83:0]        mag_reg, mag_next;
    logic signed [83:0] res_reg, res_next;
    logic [20:0]        chunk;
    logic [61:0]        pp;
    logic [83:0]        half;
    logic [83:0]        shifted;
    logic signed [83:0] prod_s;

    always_comb
    begin
        chunk   = (st_reg == M_LO) ? mb_reg[20:0] : {1'b0, mb_reg[40:21]};
        pp      = ma_reg * chunk;
        half    = rnd_reg ? (84'd1 << (sh_reg - 6'd1)) : 84'd0;
        shifted = mag_reg >> sh_reg;
        prod_s  = $signed({3'b000, acc_reg});

        st_next   = st_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        c_next    = c_reg;
        sh_next   = sh_reg;
        rnd_next  = rnd_reg;
        acc_next  = acc_reg;
        sp_next   = sp_reg;
        sgn_next  = sgn_reg;
        mag_next  = mag_reg;
        res_next  = res_reg;

        unique case (st_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    neg_next = req.a[40] ^ req.b[40];
                    ma_next  = req.a[40] ? 41'(-req.a) : 41'(req.a);
                    mb_next  = req.b[40] ? 41'(-req.b) : 41'(req.b);
                    c_next   = req.c;
                    sh_next  = req.sh;
                    rnd_next = req.rnd;
                    st_next  = M_LO;
                end
            end
            M_LO:
            begin
                acc_next = 81'(pp);
                st_next  = M_HI;
            end
            M_HI:
            begin
                acc_next = acc_reg + 81'({pp, 21'd0});
                st_next  = M_SUM;
            end
            M_SUM:
            begin
                sp_next = (neg_reg ? -prod_s : prod_s) + c_reg;
                st_next = M_ABS;
            end
            M_ABS:
            begin
                sgn_next = sp_reg[83];
                mag_next = (sp_reg[83] ? 84'(-sp_reg) : 84'(sp_reg)) + half;
                st_next  = M_RND;
            end
            M_RND:
            begin
                res_next  = sgn_reg ? -$signed(shifted) : $signed(shifted);
                done_next = 1'b1;
                st_next   = M_IDLE;
            end
            default:
            begin
                st_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= M_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        c_reg   <= c_next;
        sh_reg  <= sh_next;
        rnd_reg <= rnd_next;
        acc_reg <= acc_next;
        sp_reg  <= sp_next;
        sgn_reg <= sgn_next;
        mag_reg <= mag_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

/* hw/rtl/bcs_checker.sv */
`timescale 1ns / 1ps

module bcs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               sample_valid,
    input logic               sample_ready,
    input logic               result_valid,
    input logic               result_ready,
    input bcs_pkg::out_word_t result
);

    // A stalled result word must hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // The block works on one sample word at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("sample taken while busy");

    // A fresh result only appears after a busy cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!sample_ready))
        else $error("result appeared without work");

    // An idle block stays idle until a word arrives.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_ready && !sample_valid |=> sample_ready)
        else $error("block left idle on its own");

endmodule

bind bitmash_svf_chebyshev_shaper bcs_checker u_bcs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

/* bench/shaper_checker.sv */
`timescale 1ns / 1ps

module shaper_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    input  logic               sample_ready,
    input  bcs_pkg::in_word_t  sample,
    input  logic               result_valid,
    input  logic               result_ready,
    input  bcs_pkg::out_word_t result,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [16:0]        cfg_data,
    output int                 pending,
    output int                 errors,
    output int                 checked
);
    import bcs_pkg::*;

    typedef logic signed [127:0] wide_t;

    localparam wide_t CF_F  = 128'sd1737338;
    localparam wide_t CF_K  = 128'sd5931642;
    localparam wide_t CF_T  = 128'sd2644936;
    localparam wide_t CF_U  = 128'sd3784810;
    localparam wide_t CF_TF = 128'sd1095568;
    localparam wide_t UNIT  = 128'sd16777216;

    wide_t fold_q, kind_q, mash_q, wet_q;
    wide_t low_mem [VOICES];
    wide_t band_mem [VOICES];
    out_word_t due_q[$];

    function automatic wide_t clip(wide_t v, wide_t lo, wide_t hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic wide_t clip40(wide_t v);
        return clip(v, -(wide_t'(1) <<< 39), (wide_t'(1) <<< 39) - 1);
    endfunction

    function automatic wide_t mul_round(wide_t a, wide_t b, int sh);
        logic  neg;
        wide_t ma, mb, p;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p = (ma * mb + (wide_t'(1) <<< (sh - 1))) >>> sh;
        return neg ? -p : p;
    endfunction

    function automatic wide_t svf_step(int vc, wide_t x);
        wide_t bl, bb, lo, bd, hi;
        bl = low_mem[vc];
        bb = band_mem[vc];
        lo = clip40(mul_round(clip40(bl + mul_round(CF_TF,
                 clip40(bb + mul_round(CF_F, x, 22)), 22)), CF_U, 22));
        bd = clip40(mul_round(clip40(bb + mul_round(CF_F, clip40(x - lo), 22)), CF_T, 22));
        hi = clip40(x - lo - mul_round(CF_K, bd, 22));
        band_mem[vc] = clip40(bd + mul_round(CF_F, hi, 22));
        low_mem[vc] = clip40(lo + mul_round(CF_F, bd, 22));
        return lo;
    endfunction

    function automatic wide_t cheb_mix(wide_t y, wide_t s);
        wide_t x, x2, c3, c5, sum;
        x = mul_round(clip(y, -(wide_t'(1) <<< 35), wide_t'(1) <<< 35), s, 24);
        x = clip(x, -(wide_t'(1) <<< 26), wide_t'(1) <<< 26);
        x2 = mul_round(x, x, 24);
        c3 = mul_round(4 * x2 - 3 * UNIT, x, 24);
        c5 = mul_round(mul_round(16 * x2 - 20 * UNIT, x2, 24) + 5 * UNIT, x, 24);
        sum = c3 * (32768 - kind_q) + c5 * (32768 + kind_q);
        return mul_round(sum, 1, 17);
    endfunction

    function automatic out_word_t shape_sample(in_word_t w);
        out_word_t r;
        int        vc;
        wide_t     a, fm, sh, mag, kept, q, e, n, nm, s, ret, o, mix;
        vc = int'(w.channel) % VOICES;
        a = wide_t'(w.audio_in);
        fm = wide_t'(w.fold_mod);
        sh = clip(24 - mash_q, 0, 32);
        mag = (a < 0) ? -a : a;
        kept = mag & ~((wide_t'(1) <<< sh) - 1);
        q = (a < 0) ? -kept : kept;
        e = a - q;
        n = 2560 * fold_q + fm;
        nm = (n < 0) ? -n : n;
        s = (nm + 50) / 100;
        if (n < 0)
        begin
            s = -s;
        end
        ret = -cheb_mix(svf_step(vc, q), s);
        ret += 4 * cheb_mix(svf_step(vc, e), s);
        ret -= 6 * cheb_mix(svf_step(vc, -e), s);
        ret += 4 * cheb_mix(svf_step(vc, e), s);
        o = clip40(80 * ret);
        mix = wet_q * o + (65536 - wet_q) * q;
        mix = clip(mul_round(mix, 1, 16), -(wide_t'(1) <<< 31), (wide_t'(1) <<< 31) - 1);
        r.channel_out = w.channel;
        r.audio_out = mix[31:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            fold_q = 32768;
            kind_q = 0;
            mash_q = 23;
            wet_q = 32768;
            for (int i = 0; i < VOICES; i++)
            begin
                low_mem[i] = 0;
                band_mem[i] = 0;
            end
            due_q.delete();
            errors = 0;
            checked = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (due_q.size() == 0)
                begin
                    $display("%0t: result word with none expected: ch %0d audio %0d",
                             $time, result.channel_out, result.audio_out);
                    errors++;
                end
                else
                begin
                    want = due_q.pop_front();
                    checked++;
                    if (result.channel_out !== want.channel_out)
                    begin
                        $display("%0t: channel_out expected %0d actual %0d",
                                 $time, want.channel_out, result.channel_out);
                        errors++;
                    end
                    if (result.audio_out !== want.audio_out)
                    begin
                        $display("%0t: audio_out expected %0d actual %0d",
                                 $time, want.audio_out, result.audio_out);
                        errors++;
                    end
                end
            end
            if (sample_valid && sample_ready)
            begin
                due_q.push_back(shape_sample(sample));
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FOLD: fold_q = wide_t'({1'b0, cfg_data});
                    CFG_KIND: kind_q = wide_t'($signed(cfg_data));
                    CFG_MASH: mash_q = wide_t'($signed(cfg_data[5:0]));
                    CFG_WET:  wet_q = wide_t'({1'b0, cfg_data});
                    default: ;
                endcase
            end
        end
        pending = due_q.size();
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import bcs_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       sample_valid;
    logic       sample_ready;
    in_word_t   sample;
    logic       result_valid;
    logic       result_ready;
    out_word_t  result;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [3:0] cfg_index;
    logic [16:0] cfg_data;
    int         pending;
    int         errors;
    int         checked;
    logic       idle_on;
    logic       held;
    longint     cycles;

    bitmash_svf_chebyshev_shaper uut (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    shaper_checker chk (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pending(pending), .errors(errors), .checked(checked)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 3000000)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // The receiver stalls in bursts and holds off once for a long stretch.
    initial
    begin
        result_ready = 1'b0;
        held = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && checked >= 300)
            begin
                held = 1'b1;
                result_ready = 1'b0;
                repeat (3000) @(negedge clk);
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                result_ready = 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge clk);
            end
            else
            begin
                result_ready = 1'b1;
            end
        end
    end

    task automatic send_word(input logic [3:0] ch, input logic [31:0] a,
                             input logic [31:0] fm);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            sample_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        sample_valid = 1'b1;
        sample.channel = ch;
        sample.audio_in = a;
        sample.fold_mod = fm;
        do
            @(posedge clk);
        while (!sample_ready);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [16:0] val);
        @(negedge clk);
        sample_valid = 1'b0;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain;
        @(negedge clk);
        sample_valid = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
            2: return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
            default: return 32'($urandom_range(0, 512)) - 32'd256;
        endcase
    endfunction

    task automatic random_words(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_word(4'($urandom), pick_value(), pick_value());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FOLD;
        cfg_data = '0;
        idle_on = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_word(4'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(4'd15, 32'h8000_0000, 32'h8000_0000);
        send_word(4'd3, 32'h0000_0000, 32'h0000_0000);
        send_word(4'd3, 32'h0100_0001, 32'hFFFF_FFFF);
        send_word(4'd7, 32'hFEFF_FFFF, 32'h0000_0001);
        drain();

        write_reg(CFG_FOLD, 17'd0);
        write_reg(CFG_KIND, 17'h18000);
        write_reg(CFG_MASH, 17'h1FFFC);
        write_reg(CFG_WET, 17'd65536);
        write_reg(4'd9, 17'h1FFFF);
        send_word(4'd1, 32'h0123_4567, 32'h0000_0000);
        send_word(4'd1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(4'd15, 32'h7FFF_FFFF, 32'h8000_0000);
        drain();

        write_reg(CFG_FOLD, 17'd65536);
        write_reg(CFG_KIND, 17'd32768);
        write_reg(CFG_MASH, 17'd31);
        write_reg(CFG_WET, 17'd0);
        send_word(4'd2, 32'h0123_4567, 32'h0010_0000);
        send_word(4'd2, 32'hFFFF_FFFF, 32'hFFF0_0000);
        drain();

        write_reg(CFG_FOLD, 17'h1FFFF);
        write_reg(CFG_KIND, 17'h10000);
        write_reg(CFG_MASH, 17'h1FFE0);
        write_reg(CFG_WET, 17'h1FFFF);
        send_word(4'd4, 32'h0123_4567, 32'h0000_0000);
        send_word(4'd5, 32'h8000_0001, 32'h0800_0000);
        random_words(15);
        drain();

        write_reg(CFG_FOLD, 17'd32768);
        write_reg(CFG_KIND, 17'd0);
        write_reg(CFG_MASH, 17'd23);
        write_reg(CFG_WET, 17'd32768);
        random_words(350);
        drain();

        write_reg(CFG_FOLD, 17'd50000);
        write_reg(CFG_KIND, 17'h1C000);
        write_reg(CFG_MASH, 17'd8);
        write_reg(CFG_WET, 17'd65536);
        random_words(200);
        drain();

        write_reg(CFG_FOLD, 17'd12000);
        write_reg(CFG_KIND, 17'd16384);
        write_reg(CFG_MASH, 17'd0);
        write_reg(CFG_WET, 17'd40000);
        random_words(150);
        drain();

        idle_on = 1'b0;
        write_reg(CFG_FOLD, 17'd65536);
        write_reg(CFG_KIND, 17'h18000);
        write_reg(CFG_MASH, 17'd16);
        write_reg(CFG_WET, 17'd65536);
        random_words(200);
        drain();

        repeat (500) @(posedge clk);
        $display("Checked %0d result words over eight register settings,", checked);
        $display("including extreme samples, out-of-range steps and a long output stall.");
        if (errors == 0 && pending == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
